[hw/rtl/swmh_pkg.sv]
// Shared types and constants for the sliding-window MinHash block.
`timescale 1ns / 1ps
package swmh_pkg;
	localparam logic [63:0] MM_MUL = 64'hc6a4a7935bd1e995;
	localparam int MM_SHIFT = 47;
	localparam logic [1:0] REG_WINDOW_LEN = 2'd0;
	localparam logic [1:0] REG_HASH_SEED = 2'd1;
	localparam logic [1:0] REG_BUCKET_BITS = 2'd2;

	// One classified word handed from the front to the hash engine.
	typedef struct packed {
		logic [31:0] kmer_id;
		logic        has_marker;
		logic        last;
	} swmh_item_t;
endpackage

[hw/rtl/swmh_fifo.sv]
// Short queue between the accepting front and the hash engine.
`timescale 1ns / 1ps
module swmh_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  swmh_pkg::swmh_item_t in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output swmh_pkg::swmh_item_t out_item
);
	import swmh_pkg::*;

	swmh_item_t mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_item  = mem_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

[hw/rtl/swmh_engine.sv]
// Hash engine: window shift line, sequenced MurmurHash64A and running minimum.
`timescale 1ns / 1ps
module swmh_engine #(
	parameter int MAX_WINDOW = 16,
	parameter int KMER_BITS  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  swmh_pkg::swmh_item_t in_item,
	input  logic [4:0]           window_len,
	input  logic [63:0]          hash_seed,
	input  logic [4:0]           bucket_bits,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [127:0]         out_data
);
	import swmh_pkg::*;

	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_BLOCK = 4'd1; // k = ids * MUL
	localparam logic [3:0] ST_MIX1  = 4'd2; // k ^= k>>47; k *= MUL
	localparam logic [3:0] ST_MIX2  = 4'd3; // h ^= k; h *= MUL
	localparam logic [3:0] ST_TAIL  = 4'd4;
	localparam logic [3:0] ST_FIN1  = 4'd5;
	localparam logic [3:0] ST_FIN2  = 4'd6;
	localparam logic [3:0] ST_DONE  = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	logic [KMER_BITS-1:0] ids_q [MAX_WINDOW];
	logic [CW-1:0]        count_q;
	logic [63:0]          min_q, h_q, k_q;
	logic [3:0]           state_q;
	logic [CW-1:0]        idx_q;   // position of next id in the window
	logic [CW-1:0]        w_q;
	logic                 last_q;
	logic                 ovalid_q;
	logic [127:0]         odata_q;

	logic [CW-1:0] w_eff;
	logic [4:0]    wl;
	always_comb begin
		wl = window_len;
		if (wl == 5'd0) wl = 5'd1;
		if ({27'd0, wl} > MAX_WINDOW) w_eff = CW'(MAX_WINDOW);
		else w_eff = CW'(wl);
	end

	// Ids read at two sequencer-chosen positions from the shift line.
	logic [CW-1:0] base, p0, p1;
	logic [31:0]   id0, id1;
	assign base = CW'(MAX_WINDOW) - w_q;
	assign p0 = base + idx_q;
	assign p1 = p0 + CW'(1);
	assign id0 = 32'(ids_q[p0[IW-1:0]]);
	assign id1 = 32'(ids_q[p1[IW-1:0]]);

	logic [63:0] kx, hx, hf, mask;
	assign kx = k_q ^ (k_q >> MM_SHIFT);
	assign hx = h_q ^ k_q;
	assign hf = h_q ^ (h_q >> MM_SHIFT);

	// One 32x32 multiplier serves the hash-step products. A product takes three steps:
	// low by low, low by high and high by low, keeping only the low 64 bits.
	logic [63:0] mop, acc_q, prod, mul_res;
	logic [31:0] mul_a, mul_b;
	logic [1:0]  ph_q;
	logic        mul_act, mul_last;

	always_comb begin
		case (state_q)
			ST_BLOCK: mop = {id1, id0};
			ST_MIX1:  mop = kx;
			ST_MIX2:  mop = hx;
			ST_TAIL:  mop = h_q ^ {32'd0, id0};
			ST_FIN1:  mop = hf;
			default:  mop = '0;
		endcase
	end

	assign mul_act = (state_q == ST_BLOCK) || (state_q == ST_MIX1) || (state_q == ST_MIX2)
		|| (state_q == ST_TAIL) || (state_q == ST_FIN1);
	assign mul_last = (ph_q == 2'd2);
	assign mul_a = (ph_q == 2'd2) ? mop[63:32] : mop[31:0];
	assign mul_b = (ph_q == 2'd1) ? MM_MUL[63:32] : MM_MUL[31:0];
	assign prod = mul_a * mul_b;
	assign mul_res = acc_q + {prod[31:0], 32'd0};

	// Result fields derived from the running state.
	logic        short_rd;
	logic [63:0] mh, bkt;
	assign mask = (64'd1 << bucket_bits) - 64'd1;
	assign short_rd = count_q < w_q;
	assign mh = short_rd ? {64{1'b1}} : min_q;
	assign bkt = mh & mask;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = ovalid_q;
	assign out_data  = odata_q;

	always_ff @(posedge clk) begin
		if (mul_act) begin
			case (ph_q)
				2'd0:    acc_q <= prod;
				2'd1:    acc_q <= acc_q + {prod[31:0], 32'd0};
				default: acc_q <= acc_q;
			endcase
		end
		if (mul_last && (state_q == ST_BLOCK || state_q == ST_MIX1)) k_q <= mul_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_WINDOW; i++) ids_q[i] <= '0;
			count_q  <= '0;
			min_q    <= {64{1'b1}};
			h_q      <= '0;
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			w_q      <= '0;
			last_q   <= 1'b0;
			ovalid_q <= 1'b0;
			odata_q  <= '0;
			ph_q     <= 2'd0;
		end else begin
			if (state_q == ST_OUT && (!ovalid_q || out_ready)) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
			if (mul_act) ph_q <= mul_last ? 2'd0 : ph_q + 2'd1;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						last_q <= in_item.last;
						w_q    <= w_eff;
						idx_q  <= '0;
						h_q    <= hash_seed ^ (64'({w_eff, 2'b00}) * MM_MUL);
						if (in_item.has_marker) begin
							for (int i = 0; i < MAX_WINDOW - 1; i++) ids_q[i] <= ids_q[i+1];
							ids_q[MAX_WINDOW-1] <= in_item.kmer_id[KMER_BITS-1:0];
							if (count_q < CW'(MAX_WINDOW)) count_q <= count_q + CW'(1);
							if (count_q + CW'(1) >= w_eff || count_q == CW'(MAX_WINDOW))
								state_q <= (w_eff == CW'(1)) ? ST_TAIL : ST_BLOCK;
							else state_q <= ST_DONE;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_BLOCK: begin
					if (mul_last) state_q <= ST_MIX1;
				end
				ST_MIX1: begin
					if (mul_last) state_q <= ST_MIX2;
				end
				ST_MIX2: begin
					if (mul_last) begin
						h_q   <= mul_res;
						idx_q <= idx_q + CW'(2);
						if (idx_q + CW'(3) < w_q) state_q <= ST_BLOCK;
						else if (idx_q + CW'(2) < w_q) state_q <= ST_TAIL;
						else state_q <= ST_FIN1;
					end
				end
				ST_TAIL: begin
					if (mul_last) begin
						h_q     <= mul_res;
						state_q <= ST_FIN1;
					end
				end
				ST_FIN1: begin
					if (mul_last) begin
						h_q     <= mul_res;
						state_q <= ST_FIN2;
					end
				end
				ST_FIN2: begin
					if (hf < min_q) min_q <= hf;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					state_q <= last_q ? ST_OUT : ST_IDLE;
				end
				ST_OUT: begin
					if (!ovalid_q || out_ready) begin
						odata_q  <= {31'd0, short_rd, (bkt == mask), bkt[30:0], mh};
						count_q  <= '0;
						min_q    <= {64{1'b1}};
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[hw/rtl/sliding_window_minhash.sv]
// Top level of the sliding-window MinHash block.
`timescale 1ns / 1ps
// Streams one read's marker k-mer ids and, on the word marked last, returns the
// minimum MurmurHash64A over all windows of window_len ids (0 taken as 1, capped
// at MAX_WINDOW), its bucket index and flags. A two-entry queue decouples the
// input from the hash engine, which holds the window as a shift line and forms
// every 64-bit hash-step product in three steps on one shared 32x32 multiplier.
// The engine takes one word at a time: a marker that completes a window is hashed
// before the next word is taken, and a word marked last also waits for a free
// output register.
module sliding_window_minhash #(
	parameter int MAX_WINDOW = 16,
	parameter int KMER_BITS  = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,  // kmer_id
	input  logic         s_axis_tuser,  // has_marker
	input  logic         s_axis_tlast,  // last
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// min_hash[63:0], bucket_index[94:64], last_bucket[95], too_short[96], zero fill
	output logic [103:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	import swmh_pkg::*;

	logic [4:0]  window_len_q, bucket_bits_q;
	logic [63:0] hash_seed_q;
	swmh_item_t  in_item, q_item;
	logic        q_valid, q_ready;
	logic [127:0] res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q  <= 5'd4;
			hash_seed_q   <= '0;
			bucket_bits_q <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_LEN:  window_len_q  <= cfg_data[4:0];
				REG_HASH_SEED:   hash_seed_q   <= cfg_data;
				REG_BUCKET_BITS: bucket_bits_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign in_item = '{kmer_id: s_axis_tdata, has_marker: s_axis_tuser, last: s_axis_tlast};

	swmh_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
		.out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
	);

	swmh_engine #(.MAX_WINDOW(MAX_WINDOW), .KMER_BITS(KMER_BITS)) u_engine (
		.clk(clk), .arst_n(arst_n),
		.in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
		.window_len(window_len_q), .hash_seed(hash_seed_q), .bucket_bits(bucket_bits_q),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res)
	);

	assign m_axis_tdata = res[103:0];
endmodule
